FILE: hdl/dense_layer_forward_activation_unit_macros.svh
// Assertion macros shared by the block
`ifndef DENSE_LAYER_FORWARD_ACTIVATION_UNIT_MACROS_SVH
`define DENSE_LAYER_FORWARD_ACTIVATION_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define DLFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define DLFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define DLFA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

FILE: hdl/dlfa_pkg.sv
package dlfa_pkg;

    localparam int MAX_NEURONS = 16;
    localparam int MAX_INPUTS  = 256;
    localparam int NEURON_W    = $clog2(MAX_NEURONS);
    localparam int NCNT_W      = $clog2(MAX_NEURONS + 1);
    localparam int INPUT_W     = $clog2(MAX_INPUTS);
    localparam int ICNT_W      = 9;
    localparam int VAL_W       = 16;
    localparam int OPC_W       = 2;
    localparam int ACC_W       = 40;
    localparam int FIN_W       = ACC_W + 2;
    localparam int Z_W         = FIN_W - 12;
    localparam int TAB_W       = 13;
    localparam int TAB_N       = 256;
    localparam int MB_W        = 17;
    localparam int PROD_W      = Z_W + MB_W;
    localparam int RES_W       = 36;
    localparam int SUM_W       = $clog2(MAX_NEURONS * 4096 + 1);
    localparam int DIV_NUM_W   = 25;
    localparam int DIV_DEN_W   = SUM_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TAB_W-1:0] Q_ONE = TAB_W'(4096);
    localparam logic signed [MB_W-1:0] SELU_LAMBDA = MB_W'(4304);
    localparam logic signed [MB_W-1:0] SELU_ALPHA  = MB_W'(6854);
    localparam logic [63:0] EXP_RATIO  = 64'd4034748386;
    localparam logic [63:0] TANH_RATIO = 64'd4162825044;
    localparam logic [63:0] TWO32      = 64'd4294967296;
    localparam logic [63:0] HALF32     = 64'd2147483648;

    localparam logic [2:0] ACT_RELU    = 3'd0;
    localparam logic [2:0] ACT_LEAKY   = 3'd1;
    localparam logic [2:0] ACT_ELU     = 3'd2;
    localparam logic [2:0] ACT_SELU    = 3'd3;
    localparam logic [2:0] ACT_TANH    = 3'd4;
    localparam logic [2:0] ACT_SIGMOID = 3'd5;
    localparam logic [2:0] ACT_SWISH   = 3'd6;
    localparam logic [2:0] ACT_SOFTMAX = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_NEURONS = CFG_IDX_W'(3);

    typedef enum logic [OPC_W-1:0] {
        OP_WEIGHT  = 2'd0,
        OP_BIAS    = 2'd1,
        OP_ELEMENT = 2'd2
    } op_t;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [VAL_W-1:0] alpha;
        logic [ICNT_W-1:0]       input_count;
        logic [NCNT_W-1:0]       neuron_count;
    } cfg_t;

    typedef struct packed {
        op_t                     op;
        logic [NEURON_W-1:0]     neuron;
        logic [INPUT_W-1:0]      index;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    acc_en;
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } div_rsp_t;

    typedef logic [TAB_W-1:0] tab_t [TAB_N];

    function automatic tab_t exp_table();
        tab_t        t;
        logic [63:0] p;
        p = TWO32;
        for (int i = 0; i < TAB_N; i++)
        begin
            t[i] = TAB_W'((p * 64'd4096 + HALF32) >> 32);
            p = (p * EXP_RATIO + HALF32) >> 32;
        end
        return t;
    endfunction

    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int j = 63; j >= 0; j--)
        begin
            rem = {rem[62:0], num[j]};
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic tab_t tanh_table();
        tab_t        t;
        logic [63:0] q;
        q = TWO32;
        for (int i = 0; i < TAB_N; i++)
        begin
            t[i] = TAB_W'(long_div(64'd4096 * (TWO32 - q) + ((TWO32 + q) >> 1), TWO32 + q));
            q = (q * TANH_RATIO + HALF32) >> 32;
        end
        return t;
    endfunction

    localparam tab_t EXP_TAB  = exp_table();
    localparam tab_t TANH_TAB = tanh_table();

    function automatic logic signed [RES_W-1:0] rnd12(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] w;
        w = v + PROD_W'(2048);
        return RES_W'(w >>> 12);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat16(input logic signed [RES_W-1:0] v);
        if (v > RES_W'(32767))
            return VAL_W'(32767);
        if (v < -RES_W'(32768))
            return VAL_W'(-32768);
        return VAL_W'(v);
    endfunction

endpackage

FILE: hdl/dlfa_if.sv
interface dlfa_in_if;
    import dlfa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [OPC_W-1:0]          opcode;
    logic [NEURON_W-1:0]       neuron_index;
    logic [INPUT_W-1:0]        input_index;
    logic signed [VAL_W-1:0]   in_value;
    logic                      in_last;

    modport source (output valid, opcode, neuron_index, input_index, in_value, in_last,
                    input ready);
    modport sink (input valid, opcode, neuron_index, input_index, in_value, in_last,
                  output ready);
endinterface

interface dlfa_out_if;
    import dlfa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [NEURON_W-1:0]       out_neuron;
    logic signed [VAL_W-1:0]   out_value;
    logic                      out_last;

    modport source (output valid, out_neuron, out_value, out_last, input ready);
    modport sink (input valid, out_neuron, out_value, out_last, output ready);
endinterface

FILE: hdl/dense_layer_forward_activation_unit.sv
// Weight and bias requests are handled in the execute side as they leave the queue;
// an accumulated input element does one weight memory read per neuron in use.
// The last element adds a finalize step per neuron, then an activation pass per neuron;
// sigmoid, softmax and swish use a 1-bit divider, and softmax adds max and sum passes.
// The execute side takes one request at a time; a 2-entry queue takes requests.
// Reset: asynchronous active low; clears control and accumulators, loads register defaults.
module dense_layer_forward_activation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    dlfa_in_if.sink                             in_chan,
    dlfa_out_if.source                          out_chan,
    input  logic                                cfg_we,
    input  logic [dlfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dlfa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dlfa_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:    cfg_next.mode         = cfg_data[2:0];
                CFG_ALPHA:   cfg_next.alpha        = $signed(cfg_data[VAL_W-1:0]);
                CFG_INPUTS:  cfg_next.input_count  = cfg_data[ICNT_W-1:0];
                CFG_NEURONS: cfg_next.neuron_count = cfg_data[NCNT_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= ACT_RELU;
            cfg_reg.alpha        <= VAL_W'(41);
            cfg_reg.input_count  <= ICNT_W'(MAX_INPUTS);
            cfg_reg.neuron_count <= NCNT_W'(MAX_NEURONS);
        end
        else
            cfg_reg <= cfg_next;
    end

    dlfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_chan   (in_chan),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    dlfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .out_chan  (out_chan)
    );
endmodule

FILE: hdl/dlfa_ram.sv
module dlfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hdl/dlfa_div.sv
module dlfa_div (
    input  logic                clk,
    input  logic                rst_n,
    input  dlfa_pkg::div_req_t  req,
    output dlfa_pkg::div_rsp_t  rsp
);
    import dlfa_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W:0]   rem_shift;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_shift = {rem_reg, num_reg[DIV_NUM_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_NUM_W);
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = DIV_DEN_W'(rem_shift - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

FILE: hdl/dlfa_front.sv
module dlfa_front (
    input  logic            clk,
    input  logic            rst_n,
    input  dlfa_pkg::cfg_t  cfg,
    dlfa_in_if.sink         in_chan,
    output dlfa_pkg::cmd_t  cmd,
    output logic            cmd_valid,
    input  logic            cmd_pop
);
    import dlfa_pkg::*;

    cmd_t              queue_reg [QUEUE_DEPTH];
    cmd_t              entry;
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              take;
    logic              push;
    logic              pop;
    logic              known_op;

    assign in_chan.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign take = in_chan.valid && in_chan.ready;
    assign known_op = (in_chan.opcode == OP_WEIGHT) || (in_chan.opcode == OP_BIAS)
                   || (in_chan.opcode == OP_ELEMENT);
    assign push = take && known_op;
    assign pop  = cmd_pop && (count_reg != '0);

    always_comb
    begin
        entry.op     = op_t'(in_chan.opcode);
        entry.neuron = in_chan.neuron_index;
        entry.index  = in_chan.input_index;
        entry.value  = in_chan.in_value;
        entry.last   = in_chan.in_last;
        entry.acc_en = (in_chan.opcode == OP_ELEMENT)
                    && ({1'b0, in_chan.input_index} < cfg.input_count);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= entry;
    end

    assign cmd       = queue_reg[rd_ptr_reg];
    assign cmd_valid = (count_reg != '0);
endmodule

FILE: hdl/dlfa_back.sv
`include "dense_layer_forward_activation_unit_macros.svh"

module dlfa_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dlfa_pkg::cfg_t  cfg,
    input  dlfa_pkg::cmd_t  cmd,
    input  logic            cmd_valid,
    output logic            cmd_pop,
    dlfa_out_if.source      out_chan
);
    import dlfa_pkg::*;

    localparam int WADDR_W = NEURON_W + INPUT_W;
    localparam int IP_W    = TAB_W + 10;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_DRAIN, S_FIN, S_MAX, S_LOAD, S_INTERP,
        S_CALC, S_MUL, S_MULR, S_DIV, S_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [NEURON_W-1:0]      n_reg, n_next;
    logic signed [VAL_W-1:0]  x_reg, x_next;
    logic [INPUT_W-1:0]       pi_reg, pi_next;
    logic                     last_reg, last_next;
    logic signed [Z_W-1:0]    mx_reg, mx_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     sum_phase_reg, sum_phase_next;
    logic signed [Z_W-1:0]    zc_reg, zc_next;
    logic [TAB_W-1:0]         ta_reg, ta_next;
    logic [TAB_W-1:0]         tb_reg, tb_next;
    logic [7:0]               tf_reg, tf_next;
    logic                     tsat_reg, tsat_next;
    logic                     ttanh_reg, ttanh_next;
    logic [TAB_W-1:0]         e_reg, e_next;
    logic signed [Z_W-1:0]    ma_reg, ma_next;
    logic signed [MB_W-1:0]   mb_reg, mb_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     second_reg, second_next;
    logic signed [RES_W-1:0]  res_reg, res_next;
    div_req_t                 div_req_reg, div_req_next;
    logic                     out_valid_reg, out_valid_next;
    logic [NEURON_W-1:0]      out_neuron_reg, out_neuron_next;
    logic signed [VAL_W-1:0]  out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;

    logic signed [ACC_W-1:0]  acc_reg [MAX_NEURONS];
    logic signed [VAL_W-1:0]  bias_reg [MAX_NEURONS];
    logic signed [Z_W-1:0]    z_reg [MAX_NEURONS];

    logic                     mac_v1_reg, mac_v2_reg;
    logic [NEURON_W-1:0]      mac_n1_reg, mac_n2_reg;
    logic signed [2*VAL_W-1:0] mac_prod_reg;
    logic                     mac_issue;
    logic                     acc_clear;
    logic                     z_we;
    logic signed [Z_W-1:0]    z_wdata;
    logic                     bias_we;

    logic                     w_we;
    logic [WADDR_W-1:0]       w_waddr, w_raddr;
    logic [VAL_W-1:0]         w_rdata;
    div_rsp_t                 div_rsp;

    logic [NCNT_W-1:0]        cnt;
    logic [NEURON_W-1:0]      last_n;
    logic [NEURON_W-1:0]      acc_raddr;
    logic signed [ACC_W-1:0]  acc_rd;
    logic signed [ACC_W:0]    mac_sum;
    logic signed [FIN_W-1:0]  fin_sum;
    logic signed [Z_W-1:0]    zsel;
    logic signed [Z_W:0]      zdiff;
    logic [Z_W-1:0]           targ;
    logic [7:0]               ti;
    logic [7:0]               ti_nx;
    logic signed [TAB_W:0]    diff;
    logic signed [IP_W-1:0]   ip;
    logic signed [IP_W-1:0]   ip_r;
    logic signed [RES_W-1:0]  mul_r;
    logic [DIV_DEN_W-1:0]     sig_den;
    logic                     out_free;
    logic                     emit_fire;

    dlfa_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NEURONS * MAX_INPUTS)) u_weights (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (cmd.value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    dlfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (cfg.neuron_count == '0)
            cnt = NCNT_W'(1);
        else if (cfg.neuron_count > NCNT_W'(MAX_NEURONS))
            cnt = NCNT_W'(MAX_NEURONS);
        else
            cnt = cfg.neuron_count;
    end
    assign last_n = NEURON_W'(cnt - 1'b1);

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;
    assign w_we      = cmd_pop && (cmd.op == OP_WEIGHT);
    assign w_waddr   = {cmd.neuron, cmd.index};
    assign w_raddr   = {n_reg, pi_reg};
    assign bias_we   = cmd_pop && (cmd.op == OP_BIAS);
    assign mac_issue = (state_reg == S_MAC);
    assign acc_clear = (state_reg == S_FIN) && (n_reg == last_n);
    assign z_we      = (state_reg == S_FIN);
    assign out_free  = !out_valid_reg || out_chan.ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;

    assign acc_raddr = (state_reg == S_FIN) ? n_reg : mac_n2_reg;
    assign acc_rd    = acc_reg[acc_raddr];
    assign mac_sum   = $signed({acc_rd[ACC_W-1], acc_rd}) + (ACC_W + 1)'(mac_prod_reg);
    assign fin_sum   = $signed({{2{acc_rd[ACC_W-1]}}, acc_rd})
                     + (FIN_W'(bias_reg[n_reg]) <<< 12) + FIN_W'(2048);
    assign z_wdata   = fin_sum[FIN_W-1:12];

    assign zsel  = z_reg[n_reg];
    assign zdiff = $signed({mx_reg[Z_W-1], mx_reg}) - $signed({zsel[Z_W-1], zsel});
    always_comb
    begin
        if (cfg.mode == ACT_SOFTMAX)
            targ = zdiff[Z_W-1:0];
        else if (zsel < 0)
            targ = Z_W'(-zsel);
        else
            targ = zsel;
        if (cfg.mode == ACT_TANH)
        begin
            ti = targ[13:6];
            tf_next = {2'b00, targ[5:0]};
            tsat_next = |targ[Z_W-1:14];
        end
        else
        begin
            ti = targ[15:8];
            tf_next = targ[7:0];
            tsat_next = |targ[Z_W-1:16];
        end
    end
    assign ti_nx = ti + 1'b1;

    assign diff = $signed({1'b0, tb_reg}) - $signed({1'b0, ta_reg});
    assign ip   = diff * $signed({1'b0, tf_reg});
    assign ip_r = ttanh_reg ? ((ip + IP_W'(32)) >>> 6) : ((ip + IP_W'(128)) >>> 8);
    assign mul_r = rnd12(prod_reg);
    assign sig_den = DIV_DEN_W'(Q_ONE) + DIV_DEN_W'(e_reg);

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        x_next          = x_reg;
        pi_next         = pi_reg;
        last_next       = last_reg;
        mx_next         = mx_reg;
        sum_next        = sum_reg;
        sum_phase_next  = sum_phase_reg;
        zc_next         = zc_reg;
        ta_next         = ta_reg;
        tb_next         = tb_reg;
        ttanh_next      = ttanh_reg;
        e_next          = e_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        prod_next       = prod_reg;
        second_next     = second_reg;
        res_next        = res_reg;
        div_req_next    = div_req_reg;
        div_req_next.start = 1'b0;
        out_valid_next  = out_valid_reg && !out_chan.ready;
        out_neuron_next = out_neuron_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && (cmd.op == OP_ELEMENT))
                begin
                    x_next    = cmd.value;
                    pi_next   = cmd.index;
                    last_next = cmd.last;
                    n_next    = '0;
                    if (cmd.acc_en)
                        state_next = S_MAC;
                    else if (cmd.last)
                        state_next = S_FIN;
                end
            end
            S_MAC:
            begin
                if (n_reg == last_n)
                    state_next = S_DRAIN;
                else
                    n_next = n_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (!mac_v1_reg && !mac_v2_reg)
                begin
                    n_next = '0;
                    state_next = last_reg ? S_FIN : S_IDLE;
                end
            end
            S_FIN:
            begin
                if (n_reg == last_n)
                begin
                    n_next = '0;
                    state_next = (cfg.mode == ACT_SOFTMAX) ? S_MAX : S_LOAD;
                end
                else
                    n_next = n_reg + 1'b1;
            end
            S_MAX:
            begin
                if ((n_reg == '0) || (zsel > mx_reg))
                    mx_next = zsel;
                if (n_reg == last_n)
                begin
                    n_next = '0;
                    sum_next = '0;
                    sum_phase_next = 1'b1;
                    state_next = S_LOAD;
                end
                else
                    n_next = n_reg + 1'b1;
            end
            S_LOAD:
            begin
                zc_next    = zsel;
                ttanh_next = (cfg.mode == ACT_TANH);
                if (cfg.mode == ACT_TANH)
                begin
                    ta_next = TANH_TAB[ti];
                    tb_next = (ti == 8'hFF) ? Q_ONE : TANH_TAB[ti_nx];
                end
                else
                begin
                    ta_next = EXP_TAB[ti];
                    tb_next = (ti == 8'hFF) ? '0 : EXP_TAB[ti_nx];
                end
                state_next = S_INTERP;
            end
            S_INTERP:
            begin
                if (tsat_reg)
                    e_next = ttanh_reg ? Q_ONE : '0;
                else
                    e_next = TAB_W'($signed(IP_W'(ta_reg)) + ip_r);
                state_next = S_CALC;
            end
            S_CALC:
            begin
                case (cfg.mode)
                    ACT_RELU:
                    begin
                        res_next = (zc_reg > 0) ? RES_W'(zc_reg) : '0;
                        state_next = S_EMIT;
                    end
                    ACT_LEAKY:
                    begin
                        ma_next = zc_reg;
                        mb_next = MB_W'(cfg.alpha);
                        second_next = 1'b1;
                        res_next = RES_W'(zc_reg);
                        state_next = (zc_reg > 0) ? S_EMIT : S_MUL;
                    end
                    ACT_ELU:
                    begin
                        ma_next = Z_W'($signed({1'b0, e_reg}) - $signed({1'b0, Q_ONE}));
                        mb_next = MB_W'(cfg.alpha);
                        second_next = 1'b1;
                        res_next = RES_W'(zc_reg);
                        state_next = (zc_reg > 0) ? S_EMIT : S_MUL;
                    end
                    ACT_SELU:
                    begin
                        if (zc_reg > 0)
                        begin
                            ma_next = zc_reg;
                            mb_next = SELU_LAMBDA;
                            second_next = 1'b1;
                        end
                        else
                        begin
                            ma_next = Z_W'($signed({1'b0, e_reg}) - $signed({1'b0, Q_ONE}));
                            mb_next = SELU_ALPHA;
                            second_next = 1'b0;
                        end
                        state_next = S_MUL;
                    end
                    ACT_TANH:
                    begin
                        res_next = (zc_reg >= 0) ? RES_W'(e_reg) : -RES_W'(e_reg);
                        state_next = S_EMIT;
                    end
                    ACT_SIGMOID, ACT_SWISH:
                    begin
                        div_req_next.start = 1'b1;
                        div_req_next.den = sig_den;
                        div_req_next.num = ((zc_reg >= 0) ? DIV_NUM_W'(1 << 24)
                                                          : (DIV_NUM_W'(e_reg) << 12))
                                         + DIV_NUM_W'(sig_den >> 1);
                        state_next = S_DIV;
                    end
                    default:
                    begin
                        if (sum_phase_reg)
                        begin
                            sum_next = sum_reg + SUM_W'(e_reg);
                            if (n_reg == last_n)
                            begin
                                n_next = '0;
                                sum_phase_next = 1'b0;
                            end
                            else
                                n_next = n_reg + 1'b1;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            div_req_next.start = 1'b1;
                            div_req_next.den = DIV_DEN_W'(sum_reg);
                            div_req_next.num = (DIV_NUM_W'(e_reg) << 12)
                                             + DIV_NUM_W'(sum_reg >> 1);
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL:
            begin
                prod_next = ma_reg * mb_reg;
                state_next = S_MULR;
            end
            S_MULR:
            begin
                if (!second_reg)
                begin
                    ma_next = Z_W'(mul_r);
                    mb_next = SELU_LAMBDA;
                    second_next = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    res_next = mul_r;
                    state_next = S_EMIT;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (cfg.mode == ACT_SWISH)
                    begin
                        ma_next = zc_reg;
                        mb_next = MB_W'(div_rsp.quo[TAB_W-1:0]);
                        second_next = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        res_next = RES_W'(div_rsp.quo);
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_neuron_next = n_reg;
                    out_value_next  = sat16(res_reg);
                    out_last_next   = (n_reg == last_n);
                    if (n_reg == last_n)
                        state_next = S_IDLE;
                    else
                    begin
                        n_next = n_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            n_reg              <= '0;
            sum_phase_reg      <= 1'b0;
            second_reg         <= 1'b0;
            last_reg           <= 1'b0;
            div_req_reg.start  <= 1'b0;
            div_req_reg.num    <= '0;
            div_req_reg.den    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            n_reg              <= n_next;
            sum_phase_reg      <= sum_phase_next;
            second_reg         <= second_next;
            last_reg           <= last_next;
            div_req_reg        <= div_req_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        pi_reg         <= pi_next;
        mx_reg         <= mx_next;
        sum_reg        <= sum_next;
        zc_reg         <= zc_next;
        ta_reg         <= ta_next;
        tb_reg         <= tb_next;
        tf_reg         <= tf_next;
        tsat_reg       <= tsat_next;
        ttanh_reg      <= ttanh_next;
        e_reg          <= e_next;
        ma_reg         <= ma_next;
        mb_reg         <= mb_next;
        prod_reg       <= prod_next;
        res_reg        <= res_next;
        out_neuron_reg <= out_neuron_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        if (bias_we)
            bias_reg[cmd.neuron] <= cmd.value;
        if (z_we)
            z_reg[n_reg] <= z_wdata;
        mac_prod_reg <= $signed(w_rdata) * x_reg;
        mac_n1_reg   <= n_reg;
        mac_n2_reg   <= mac_n1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_v1_reg <= 1'b0;
            mac_v2_reg <= 1'b0;
            for (int i = 0; i < MAX_NEURONS; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            mac_v1_reg <= mac_issue;
            mac_v2_reg <= mac_v1_reg;
            if (acc_clear)
            begin
                for (int i = 0; i < MAX_NEURONS; i++)
                    acc_reg[i] <= '0;
            end
            else if (mac_v2_reg)
            begin
                if (mac_sum[ACC_W] != mac_sum[ACC_W-1])
                    acc_reg[mac_n2_reg] <= mac_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                          : {1'b0, {(ACC_W-1){1'b1}}};
                else
                    acc_reg[mac_n2_reg] <= mac_sum[ACC_W-1:0];
            end
        end
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.out_neuron = out_neuron_reg;
    assign out_chan.out_value  = out_value_reg;
    assign out_chan.out_last   = out_last_reg;

    `DLFA_ASSERT(a_div_idle, clk, rst_n, div_req_reg.start |-> !div_rsp.busy, "divider restarted while busy")
    `DLFA_ASSERT_NEXT(a_last_idle, clk, rst_n, emit_fire && (n_reg == last_n), state_reg == S_IDLE, "run did not end after last neuron")
    `DLFA_ASSERT(a_mac_index, clk, rst_n, mac_v2_reg |-> (mac_n2_reg <= last_n), "accumulate beyond neurons in use")
    `DLFA_ASSERT(a_fin_drained, clk, rst_n, (state_reg == S_FIN) |-> (!mac_v1_reg && !mac_v2_reg), "finalize with accumulate in flight")
endmodule
